// ===== design/psclim_pkg.sv =====
package psclim_pkg;

    // Field widths fixed by the event and result formats.
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 16;
    localparam int VERDICT_W = 2;

    // Default table geometry.
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Event kinds.
    localparam logic CMD_OPEN  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT       = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_MANY     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_MANY_SRC = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TABLE_FULL   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIENTS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SOURCE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] src_addr;
    } t_in_item;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [CNT_W-1:0]     live_total;
        logic [CNT_W-1:0]     live_for_source;
    } t_out_item;

    // One way of the per-source table as stored in memory.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] key;
        logic [CNT_W-1:0]  count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== design/psclim_ram.sv =====
module psclim_ram import psclim_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = BUCKETS_DEF * WAYS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/per_source_connection_limiter.sv =====
// Flow: an accepted item goes through ST_RD and ST_CMP once for each way read
// (1..WAYS, the scan stops at a hit), then through ST_UPD, which loads the result
// into the output register. One item is in work at a time; the next is taken in
// ST_IDLE, and ST_UPD waits while a result is held in a stalled output register.
// Reset: synchronous, active low. After reset the block clears the table, one
// entry a cycle, all BUCKETS*WAYS entries (1024 by default), before taking items.
module per_source_connection_limiter import psclim_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Event input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,

    // Result output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,

    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int ENTRIES  = BUCKETS * WAYS;
    localparam int ENTRY_AW = $clog2(ENTRIES);
    localparam int SET_W    = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [WAY_W-1:0]     LAST_WAY  = WAY_W'(WAYS - 1);
    localparam logic [ENTRY_AW-1:0]  LAST_ENT  = ENTRY_AW'(ENTRIES - 1);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;

    logic [2:0]           r_state,       n_state;
    logic [ENTRY_AW-1:0]  r_clr_cnt,     n_clr_cnt;
    logic                 r_cmd,         n_cmd;
    logic [ADDR_W-1:0]    r_key,         n_key;
    logic [SET_W-1:0]     r_rem,         n_rem;
    logic [WAY_W-1:0]     r_way,         n_way;
    logic                 r_hit,         n_hit;
    logic [WAY_W-1:0]     r_hit_way,     n_hit_way;
    logic                 r_free_ok,     n_free_ok;
    logic [WAY_W-1:0]     r_free_way,    n_free_way;
    logic [CNT_W-1:0]     r_cnt,         n_cnt;
    logic [CNT_W-1:0]     r_total,       n_total;
    logic [CNT_W-1:0]     r_max_clients, n_max_clients;
    logic [CNT_W-1:0]     r_max_per_src, n_max_per_src;
    logic                 r_out_valid,   n_out_valid;
    t_out_item            r_out_data,    n_out_data;

    logic                 ram_wr_en;
    logic [ENTRY_AW-1:0]  ram_wr_addr;
    t_entry               ram_wr_data;
    logic                 ram_rd_en;
    logic [ENTRY_AW-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0]   ram_rd_data;

    // The whole table lives in one memory: entry (set * WAYS + way) holds one
    // way. Valid bits travel with the entry, so reset needs a clearing pass.
    psclim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // First entry of the selected set.
    logic [ENTRY_AW-1:0] set_base;
    assign set_base = ENTRY_AW'(r_rem) * ENTRY_AW'(WAYS);

    // Shared key compare against the way just read.
    t_entry rd_ent;
    logic   way_match;
    assign rd_ent    = t_entry'(ram_rd_data);
    assign way_match = rd_ent.valid && (rd_ent.key == r_key);

    // Update arithmetic used in the final step.
    logic [CNT_W-1:0] total_inc;
    logic [CNT_W-1:0] total_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;

    assign total_inc = (r_total != CNT_MAX) ? (r_total + 1'b1) : r_total;
    assign total_dec = (r_total != '0) ? (r_total - 1'b1) : r_total;
    assign cnt_inc   = (r_cnt != CNT_MAX) ? (r_cnt + 1'b1) : r_cnt;
    assign cnt_dec   = (r_cnt != '0) ? (r_cnt - 1'b1) : r_cnt;

    logic [CNT_W-1:0] upd_total;
    logic [CNT_W-1:0] upd_src;

    always_comb begin
        n_state       = r_state;
        n_clr_cnt     = r_clr_cnt;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_rem         = r_rem;
        n_way         = r_way;
        n_hit         = r_hit;
        n_hit_way     = r_hit_way;
        n_free_ok     = r_free_ok;
        n_free_way    = r_free_way;
        n_cnt         = r_cnt;
        n_total       = r_total;
        n_max_clients = r_max_clients;
        n_max_per_src = r_max_per_src;
        n_out_data    = r_out_data;
        // A waiting result leaves the output register once it is taken.
        n_out_valid   = r_out_valid && i_out_stall;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = set_base + ENTRY_AW'(r_way);

        upd_total = r_total;
        upd_src   = '0;

        // Configuration must be written only while no item is in work; the block itself does not enforce it.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_CLIENTS:    n_max_clients = i_cfg_data;
                CFG_MAX_PER_SOURCE: n_max_per_src = i_cfg_data;
                default:            ;
            endcase
        end

        unique case (r_state)
            ST_CLEAR: begin
                // Write an empty entry at every address once after reset.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_cnt;
                n_clr_cnt   = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_ENT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    // BUCKETS is a power of two, so the address modulo the
                    // bucket count is just its low bits.
                    n_cmd     = i_in_data.cmd;
                    n_key     = i_in_data.src_addr;
                    n_rem     = i_in_data.src_addr[SET_W-1:0];
                    n_way     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = ST_RD;
                end
            end
            ST_RD: begin
                ram_rd_en = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                // Keys are unique within a set, so the scan stops at a hit. The
                // lowest free way is remembered for a possible new entry.
                if (way_match) begin
                    n_hit     = 1'b1;
                    n_hit_way = r_way;
                    n_cnt     = rd_ent.count;
                    n_state   = ST_UPD;
                end else begin
                    if (!rd_ent.valid && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_way = r_way;
                    end
                    if (r_way == LAST_WAY) begin
                        n_state = ST_UPD;
                    end else begin
                        n_way   = r_way + 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_UPD: begin
                // Write back and build the result once the output register
                // has room for it.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data.verdict = VERDICT_ACCEPT;
                    if (r_cmd == CMD_OPEN) begin
                        if (r_hit) begin
                            upd_total   = total_inc;
                            upd_src     = cnt_inc;
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = set_base + ENTRY_AW'(r_hit_way);
                            ram_wr_data = '{valid: 1'b1, key: r_key, count: cnt_inc};
                        end else if (r_free_ok) begin
                            upd_total   = total_inc;
                            upd_src     = CNT_W'(1);
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = set_base + ENTRY_AW'(r_free_way);
                            ram_wr_data = '{valid: 1'b1, key: r_key, count: CNT_W'(1)};
                        end
                        // The connection stays counted even when refused by a
                        // limit; a full set refuses it and changes nothing.
                        if (!r_hit && !r_free_ok) begin
                            n_out_data.verdict = VERDICT_TABLE_FULL;
                        end else if ((r_max_clients != '0) && (upd_total > r_max_clients)) begin
                            n_out_data.verdict = VERDICT_TOO_MANY;
                        end else if ((r_max_per_src != '0) && (upd_src > r_max_per_src)) begin
                            n_out_data.verdict = VERDICT_TOO_MANY_SRC;
                        end
                    end else begin
                        upd_total = total_dec;
                        if (r_hit) begin
                            // An entry whose count reaches zero is freed.
                            upd_src     = cnt_dec;
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = set_base + ENTRY_AW'(r_hit_way);
                            ram_wr_data = '{valid: (cnt_dec != '0), key: r_key,
                                            count: cnt_dec};
                        end
                    end
                    n_total                    = upd_total;
                    n_out_data.live_total      = upd_total;
                    n_out_data.live_for_source = upd_src;
                    n_out_valid                = 1'b1;
                    n_state                    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_cnt     <= '0;
            r_total       <= '0;
            r_max_clients <= '0;
            r_max_per_src <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_cnt     <= n_clr_cnt;
            r_total       <= n_total;
            r_max_clients <= n_max_clients;
            r_max_per_src <= n_max_per_src;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_rem      <= n_rem;
        r_way      <= n_way;
        r_hit      <= n_hit;
        r_hit_way  <= n_hit_way;
        r_free_ok  <= n_free_ok;
        r_free_way <= n_free_way;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    // An item is taken only between events; a result may still wait meanwhile.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // No result can appear while the table is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_out_valid)
        else $error("result presented during table clearing");

    // A refused open on a full set never reports a per-source count.
    a_full_has_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.verdict == VERDICT_TABLE_FULL))
            |-> (o_out_data.live_for_source == '0))
        else $error("table full result with nonzero source count");

    // The way scan never runs past the last way of a set.
    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) || (r_state == ST_CMP)) |-> (r_way <= LAST_WAY))
        else $error("way index out of range");

    // A result is loaded only by the update step, which then returns to idle.
    a_load_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> ($past(r_state) == ST_UPD) && (r_state == ST_IDLE))
        else $error("result loaded outside the update step");

endmodule

// ===== tb/sv/tb_per_source_connection_limiter.sv =====
module tb_per_source_connection_limiter import psclim_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // The run ends early if no item has moved on any channel for this many cycles.
    // This allows for the table clear after reset, the longest scan and the
    // longest stall, with plenty of margin.
    localparam int QUIET_LIMIT = 6000;
    localparam int ENTRIES     = BUCKETS_DEF * WAYS_DEF;
    localparam int POOL_SIZE   = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data  = '0;

    per_source_connection_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Our own copy of the connection table, the global live count and the
    // two limits. The table starts empty, which matches the state after the
    // clearing pass that follows reset.
    logic [ADDR_W-1:0] slot_key  [ENTRIES];
    logic [CNT_W-1:0]  slot_cnt  [ENTRIES];
    bit                slot_used [ENTRIES];
    logic [CNT_W-1:0]  live_sum    = '0;
    logic [CNT_W-1:0]  lim_clients = '0;
    logic [CNT_W-1:0]  lim_source  = '0;

    // Events waiting to be sent; an event leaves this queue only when the
    // block accepts it, so the queue and the verdict queue never both look
    // empty while an event is still on its way.
    t_in_item  events_pending [$];
    t_out_item verdicts_due   [$];

    int mismatches   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int tx_gap       = 0;
    int rx_hold      = 0;
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;
    t_out_item rx_want;

    // Applies one open or close event to the table copy and returns the
    // result the block must give for it.
    function automatic t_out_item count_event(input t_in_item ev);
        int               base;
        int               hit;
        int               spare;
        int               w;
        logic [CNT_W-1:0] src_n;
        t_out_item        res;
        base  = int'(ev.src_addr % BUCKETS_DEF) * WAYS_DEF;
        hit   = -1;
        spare = -1;
        src_n = '0;
        res   = '0;
        res.verdict = VERDICT_ACCEPT;
        for (w = 0; w < WAYS_DEF; w++) begin
            if (hit < 0 && slot_used[base + w] && slot_key[base + w] == ev.src_addr) begin
                hit = base + w;
            end
            // The lowest free way is the one a new address takes.
            if (spare < 0 && !slot_used[base + w]) begin
                spare = base + w;
            end
        end
        if (ev.cmd == CMD_OPEN) begin
            if (hit < 0 && spare < 0) begin
                // A new address in a full set is refused and nothing changes.
                res.verdict         = VERDICT_TABLE_FULL;
                res.live_total      = live_sum;
                res.live_for_source = '0;
                return res;
            end
            if (hit < 0) begin
                slot_used[spare] = 1'b1;
                slot_key[spare]  = ev.src_addr;
                slot_cnt[spare]  = CNT_W'(1);
                src_n            = CNT_W'(1);
            end else begin
                if (slot_cnt[hit] != CNT_MAX) begin
                    slot_cnt[hit] = slot_cnt[hit] + 1'b1;
                end
                src_n = slot_cnt[hit];
            end
            if (live_sum != CNT_MAX) begin
                live_sum = live_sum + 1'b1;
            end
            // The connection stays counted even when it is over a limit.
            if (lim_clients != 0 && live_sum > lim_clients) begin
                res.verdict = VERDICT_TOO_MANY;
            end else if (lim_source != 0 && src_n > lim_source) begin
                res.verdict = VERDICT_TOO_MANY_SRC;
            end
        end else begin
            // A close always takes one off the global count, which floors at
            // zero; an unknown address touches nothing else.
            if (live_sum != 0) begin
                live_sum = live_sum - 1'b1;
            end
            if (hit >= 0) begin
                if (slot_cnt[hit] != 0) begin
                    slot_cnt[hit] = slot_cnt[hit] - 1'b1;
                end
                src_n = slot_cnt[hit];
                if (src_n == 0) begin
                    slot_used[hit] = 1'b0;
                end
            end
        end
        res.live_total      = live_sum;
        res.live_for_source = src_n;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        mismatches++;
    endtask

    // Waiting time before the next item on one side. Now and then a side
    // flips into a calm stretch where it never waits, and back again.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 23) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Event driver. A new item goes on the bus only when the previous one
    // has been taken or the bus was empty, and a stalled item holds still.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                verdicts_due.push_back(count_event(events_pending.pop_front()));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (events_pending.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= events_pending[0];
                    tx_gap      = draw_wait(tx_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result is held off for a drawn number of cycles
    // once it shows up, then taken and compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with no event pending",
                                         results_seen));
                end else begin
                    rx_want = verdicts_due.pop_front();
                    if (o_out_data.verdict !== rx_want.verdict) begin
                        flag_error($sformatf("result %0d: verdict %0d, expected %0d",
                                             results_seen, o_out_data.verdict,
                                             rx_want.verdict));
                    end
                    if (o_out_data.live_total !== rx_want.live_total) begin
                        flag_error($sformatf("result %0d: live_total %0d, expected %0d",
                                             results_seen, o_out_data.live_total,
                                             rx_want.live_total));
                    end
                    if (o_out_data.live_for_source !== rx_want.live_for_source) begin
                        flag_error($sformatf("result %0d: live_for_source %0d, expected %0d",
                                             results_seen, o_out_data.live_for_source,
                                             rx_want.live_for_source));
                    end
                end
                rx_hold = draw_wait(rx_calm);
            end else if (o_out_valid && rx_hold != 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_hold != 0);
        end
    end

    // Watchdog: too long with no item moving on any channel ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_per_source_connection_limiter: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one limit register and mirrors it in the model once taken.
    // Called only while no event is in the block.
    task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MAX_CLIENTS) begin
            lim_clients = val;
        end else begin
            lim_source = val;
        end
    endtask

    task automatic add_event(input logic cmd, input logic [ADDR_W-1:0] addr);
        t_in_item ev;
        ev.cmd      = cmd;
        ev.src_addr = addr;
        events_pending.push_back(ev);
    endtask

    // Random traffic for one phase. Most events open and close addresses
    // from a small pool squeezed into two sets, so entries get reused, counts
    // climb past the limits and the first set overflows its ways. A few
    // events are pure noise over the whole address space.
    task automatic queue_traffic(input int count);
        logic [ADDR_W-1:0] pool [POOL_SIZE];
        logic [ADDR_W-1:0] hi;
        int                set_a;
        int                set_b;
        int                k;
        set_a = $urandom_range(0, BUCKETS_DEF - 1);
        set_b = $urandom_range(0, BUCKETS_DEF - 1);
        for (k = 0; k < POOL_SIZE; k++) begin
            hi      = $urandom();
            pool[k] = hi - (hi % BUCKETS_DEF) + ((k < WAYS_DEF + 1) ? set_a : set_b);
        end
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                add_event(1'($urandom_range(0, 1)), $urandom());
            end else begin
                add_event(($urandom_range(0, 99) < 55) ? CMD_OPEN : CMD_CLOSE,
                          pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
        end
    endtask

    task automatic wait_drained();
        while (events_pending.size() != 0 || verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int phase_idx;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with a global limit of three and two per address.
        set_limit(CFG_MAX_CLIENTS, 16'd3);
        set_limit(CFG_MAX_PER_SOURCE, 16'd2);
        // Close of an unknown address while nothing is live.
        add_event(CMD_CLOSE, 32'h0000_0000);
        // The same address opened three times; the third is over its limit.
        add_event(CMD_OPEN,  32'hFFFF_FFFF);
        add_event(CMD_OPEN,  32'hFFFF_FFFF);
        add_event(CMD_OPEN,  32'hFFFF_FFFF);
        // A fourth connection is over the global limit.
        add_event(CMD_OPEN,  32'h0000_0000);
        // Fill the rest of the set that holds the all-ones address.
        add_event(CMD_OPEN,  32'h0000_00FF);
        add_event(CMD_OPEN,  32'h5A5A_5AFF);
        add_event(CMD_OPEN,  32'hA5A5_A5FF);
        // A fifth address in that set finds no free way.
        add_event(CMD_OPEN,  32'h8000_00FF);
        // Freeing one way lets the same address in on the lowest free way.
        add_event(CMD_CLOSE, 32'h0000_00FF);
        add_event(CMD_OPEN,  32'h8000_00FF);
        // Close of an address that was never opened.
        add_event(CMD_CLOSE, 32'h1234_5678);
        // Drain everything, and once more past zero to hit the floor.
        add_event(CMD_CLOSE, 32'hFFFF_FFFF);
        add_event(CMD_CLOSE, 32'hFFFF_FFFF);
        add_event(CMD_CLOSE, 32'hFFFF_FFFF);
        add_event(CMD_CLOSE, 32'h0000_0000);
        add_event(CMD_CLOSE, 32'h8000_00FF);
        add_event(CMD_CLOSE, 32'h5A5A_5AFF);
        add_event(CMD_CLOSE, 32'hA5A5_A5FF);
        add_event(CMD_CLOSE, 32'h7FFF_FFFF);
        wait_drained();

        // Random phases, each under its own pair of limits. The table and
        // the live count carry over from phase to phase.
        for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
            unique case (phase_idx)
                0: begin
                    set_limit(CFG_MAX_CLIENTS, 16'd0);
                    set_limit(CFG_MAX_PER_SOURCE, 16'd0);
                end
                1: begin
                    set_limit(CFG_MAX_CLIENTS, CNT_MAX);
                    set_limit(CFG_MAX_PER_SOURCE, CNT_MAX);
                end
                2: begin
                    set_limit(CFG_MAX_CLIENTS, 16'd1);
                    set_limit(CFG_MAX_PER_SOURCE, 16'd1);
                end
                3: begin
                    set_limit(CFG_MAX_CLIENTS, 16'd0);
                    set_limit(CFG_MAX_PER_SOURCE, 16'd2);
                end
                4: begin
                    set_limit(CFG_MAX_CLIENTS, 16'd4);
                    set_limit(CFG_MAX_PER_SOURCE, 16'd0);
                end
                5: begin
                    set_limit(CFG_MAX_CLIENTS, 16'($urandom_range(1, 8)));
                    set_limit(CFG_MAX_PER_SOURCE, 16'($urandom_range(1, 4)));
                end
                6: begin
                    set_limit(CFG_MAX_CLIENTS, 16'($urandom_range(0, 65535)));
                    set_limit(CFG_MAX_PER_SOURCE, 16'($urandom_range(0, 65535)));
                end
                default: begin
                    set_limit(CFG_MAX_CLIENTS, 16'd2);
                    set_limit(CFG_MAX_PER_SOURCE, 16'd1);
                end
            endcase
            queue_traffic(60);
            wait_drained();
        end

        // Give a stray extra result time to show up before the verdict.
        repeat (48) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_per_source_connection_limiter: clean");
        end else begin
            $display("tb_per_source_connection_limiter: errors");
        end
        $finish;
    end

endmodule
